// ===== rtl/core/fir_filter_direct_form_macros.svh =====
// Assertion macros for the direct-form FIR filter.
// Used by the RTL files that carry checks; the modules must provide clk and rst_n.
`ifndef FIR_FILTER_DIRECT_FORM_MACROS_SVH
`define FIR_FILTER_DIRECT_FORM_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define FIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FIR_ASSERT_NOW(lbl, ante, cons, msg)
`define FIR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/fir_pkg.sv =====
// Shared constants and types for the direct-form FIR filter.
// No dependencies; compiled before every other RTL file.
package fir_pkg;

  localparam int TAPS        = 64;
  localparam int SMP_W       = 16;
  localparam int COEF_W      = 16;
  localparam int COEF_IDX_W  = 6;
  localparam int PROD_W      = SMP_W + COEF_W;
  localparam int ACC_W       = 38;
  localparam int TAP_BITS    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int IDX_W       = (TAP_BITS > COEF_IDX_W) ? TAP_BITS : COEF_IDX_W;

  typedef enum logic {
    REQ_COEF   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_t;

  // One wavefront travelling down the tap chain, one cell per enabled cycle.
  typedef struct packed {
    logic                     valid;
    logic                     is_sample;
    logic                     first;
    logic [COEF_IDX_W-1:0]    idx;
    logic signed [COEF_W-1:0] coef;
    logic signed [SMP_W-1:0]  smp;   // sample shifted out of the previous cell
    logic signed [ACC_W-1:0]  acc;
    logic signed [PROD_W-1:0] prod;  // product of the previous cell, added here
  } wave_t;

endpackage

// ===== rtl/core/fir_if.sv =====
// Valid/ready channel interfaces for the FIR filter input and result beats.
// Depends on fir_pkg for the field widths.
interface fir_in_if;
  import fir_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [COEF_IDX_W-1:0]    coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic signed [SMP_W-1:0]  sample_value;
  logic                     first_sample;

  modport source (output valid, req_type, coef_index, coef_value, sample_value,
                  first_sample, input ready);
  modport sink   (input valid, req_type, coef_index, coef_value, sample_value,
                  first_sample, output ready);
endinterface

interface fir_out_if;
  import fir_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] filtered_value;

  modport source (output valid, filtered_value, input ready);
  modport sink   (input valid, filtered_value, output ready);
endinterface

// ===== rtl/core/fir_filter_direct_form.sv =====
// Direct-form FIR filter, Q1.15 data and coefficients, 38-bit exact sum.
// Channels: in_ch carries coefficient loads (req_type 0) and samples
// (req_type 1); out_ch carries one filtered_value beat per sample.
// A coefficient load writes tap coef_index; indexes at or beyond TAPS are
// dropped. All taps should be loaded before samples are sent.
// Each beat travels down a row of TAPS cells, one cell per clock while
// the chain is enabled, so loads and samples keep their order; each cell
// does one 16x16 multiply and one add. A sample's sum passes the register
// of every cell and then the output register. Throughput: one beat per
// clock, loads and samples alike, while in_ch.ready stays high.
// first_sample zeroes the sample history before that sample enters.
// Reset (rst_n low, synchronous) empties the chain and zeroes the delay
// line; coefficients are not cleared.
// Receiver stall: the output register holds its beat and one more result
// parks in a skid register; only then does in_ch.ready drop and the whole
// chain freeze until out_ch.ready returns.
module fir_filter_direct_form (
  input  logic      clk,
  input  logic      rst_n,
  fir_in_if.sink    in_ch,
  fir_out_if.source out_ch
);
  import fir_pkg::*;

  wave_t waves [TAPS+1];
  logic  en;

  always_comb begin
    waves[0]           = '0;
    waves[0].valid     = in_ch.valid;
    waves[0].is_sample = (in_ch.req_type == REQ_SAMPLE);
    waves[0].first     = in_ch.first_sample;
    waves[0].idx       = in_ch.coef_index;
    waves[0].coef      = in_ch.coef_value;
    waves[0].smp       = in_ch.sample_value;
  end

  assign in_ch.ready = en;

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    fir_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .tap_idx (IDX_W'(k)),
      .w_in    (waves[k]),
      .w_out   (waves[k+1])
    );
  end

  fir_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .tail      (waves[TAPS]),
    .en        (en),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.filtered_value)
  );

endmodule

// ===== rtl/core/fir_cell.sv =====
// One tap of the systolic FIR chain: coefficient, delay-line sample and a
// multiply/accumulate step. Depends on fir_pkg.
module fir_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [fir_pkg::IDX_W-1:0] tap_idx,
  input  fir_pkg::wave_t          w_in,
  output fir_pkg::wave_t          w_out
);
  import fir_pkg::*;

  logic signed [COEF_W-1:0] coef_r;
  logic signed [SMP_W-1:0]  dl_r;
  wave_t                    w_r;
  wave_t                    w_nxt;
  logic                     act;
  logic                     hit;

  assign act = en && w_in.valid;
  assign hit = (IDX_W'(w_in.idx) == tap_idx);

  always_comb begin
    w_nxt      = w_in;
    // first-sample flag empties the rest of the line behind this beat
    w_nxt.smp  = w_in.first ? '0 : dl_r;
    w_nxt.acc  = w_in.acc + ACC_W'(w_in.prod);
    w_nxt.prod = PROD_W'(coef_r * w_in.smp);
  end

  always_ff @(posedge clk) begin
    if (act && !w_in.is_sample && hit) begin
      coef_r <= w_in.coef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r <= '0;
    end else if (act && w_in.is_sample) begin
      dl_r <= w_in.smp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.valid <= 1'b0;
    end else if (en) begin
      w_r <= w_nxt;
    end
  end

  assign w_out = w_r;

endmodule

// ===== rtl/core/fir_out.sv =====
// Final accumulate and output register with one skid beat; also produces
// the chain advance enable. Depends on fir_pkg and the assertion macros.
`include "fir_filter_direct_form_macros.svh"

module fir_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fir_pkg::wave_t               tail,
  output logic                         en,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [fir_pkg::ACC_W-1:0] out_data
);
  import fir_pkg::*;

  logic                    out_valid_r, out_valid_nxt;
  logic                    skid_valid_r, skid_valid_nxt;
  logic signed [ACC_W-1:0] out_data_r, out_data_nxt;
  logic signed [ACC_W-1:0] skid_data_r, skid_data_nxt;
  logic                    res_valid;
  logic signed [ACC_W-1:0] res;
  logic                    out_free;

  assign en        = !skid_valid_r;
  assign res_valid = tail.valid && tail.is_sample;
  assign res       = tail.acc + ACC_W'(tail.prod);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (en && res_valid) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end
    end else if (en && res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FIR_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with empty output")
  `FIR_ASSERT_NEXT(a_stall_to_skid, en && res_valid && out_valid_r && !out_ready, skid_valid_r, "result lost on stall")
  `FIR_ASSERT_NEXT(a_skid_drain, out_valid_r && out_ready && skid_valid_r, out_valid_r && !skid_valid_r, "skid beat not drained")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the direct-form FIR filter: coefficient loads and samples
// go in over fir_in_if, filtered_value beats are checked against an in-bench predictor.
// Depends on fir_pkg and the fir_in_if / fir_out_if interfaces from the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fir_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 360;
  localparam int CALM_ITEMS   = 60;

  typedef struct {
    req_t                     kind;
    logic [COEF_IDX_W-1:0]    idx;
    logic signed [COEF_W-1:0] coef;
    logic signed [SMP_W-1:0]  smp;
    logic                     first;
  } fir_req_t;

  logic clk = 1'b0;
  logic rst_n;
  logic calm = 1'b0;
  int   fail_count = 0;
  int   cycle_count = 0;

  // predictor state
  logic signed [SMP_W-1:0]  tap_history [TAPS];
  logic signed [COEF_W-1:0] tap_coefs [TAPS];
  logic signed [ACC_W-1:0]  expected_sums [$];

  fir_in_if  in_ch();
  fir_out_if out_ch();

  fir_filter_direct_form u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10ns clk = 1'b1;
    #10ns clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [ACC_W-1:0] filter_sample(logic signed [SMP_W-1:0] smp,
                                                            logic first);
    longint acc;
    acc = 0;
    if (first) begin
      for (int k = 0; k < TAPS; k++) tap_history[k] = '0;
    end
    for (int k = TAPS - 1; k > 0; k--) tap_history[k] = tap_history[k-1];
    tap_history[0] = smp;
    for (int k = 0; k < TAPS; k++)
      acc += longint'(tap_coefs[k]) * longint'(tap_history[k]);
    return acc[ACC_W-1:0];
  endfunction

  // ---------------------------------------------------------------- item builders
  function automatic logic signed [15:0] pick_q15();
    case ($urandom_range(0, 11))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // unused fields always carry random junk
  function automatic fir_req_t coef_load(int idx, logic signed [COEF_W-1:0] coef);
    fir_req_t r;
    r.kind  = REQ_COEF;
    r.idx   = COEF_IDX_W'(idx);
    r.coef  = coef;
    r.smp   = SMP_W'($urandom);
    r.first = 1'($urandom);
    return r;
  endfunction

  function automatic fir_req_t sample_beat(logic signed [SMP_W-1:0] smp, logic first);
    fir_req_t r;
    r.kind  = REQ_SAMPLE;
    r.idx   = COEF_IDX_W'($urandom);
    r.coef  = COEF_W'($urandom);
    r.smp   = smp;
    r.first = first;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  task automatic send_beat(fir_req_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= r.kind;
    in_ch.coef_index   <= r.idx;
    in_ch.coef_value   <= r.coef;
    in_ch.sample_value <= r.smp;
    in_ch.first_sample <= r.first;
    do @(posedge clk); while (!in_ch.ready);
    if (r.kind == REQ_COEF) begin
      if (int'(r.idx) < TAPS) tap_coefs[r.idx] = r.coef;
    end else begin
      expected_sums.push_back(filter_sample(r.smp, r.first));
    end
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    logic signed [ACC_W-1:0] want;
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      if (expected_sums.size() == 0) begin
        $error("filtered_value: expected none, got %0d", out_ch.filtered_value);
        fail_count++;
      end else begin
        want = expected_sums.pop_front();
        if (out_ch.filtered_value !== want) begin
          $error("filtered_value: expected %0d, got %0d", want, out_ch.filtered_value);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // every tap must hold a value before any sample goes in
  task automatic test_coef_fill();
    for (int k = 0; k < TAPS; k++) send_beat(coef_load(k, 16'sh8000));
  endtask

  task automatic test_field_extremes();
    send_beat(sample_beat(16'sh8000, 1'b0));   // history still zero from reset
    send_beat(sample_beat(16'sh7fff, 1'b0));
    send_beat(sample_beat(16'sh0000, 1'b0));
    send_beat(sample_beat(16'shffff, 1'b0));
    send_beat(sample_beat(16'sh0001, 1'b0));
    send_beat(coef_load(0, 16'sh7fff));
    send_beat(coef_load(TAPS - 1, 16'shffff));
    send_beat(coef_load(TAPS / 2, 16'sh0000));
    send_beat(coef_load(21, 16'sh5555));
    send_beat(coef_load(42, 16'shaaaa));
    send_beat(sample_beat(16'sh7fff, 1'b0));
    send_beat(sample_beat(16'sh8000, 1'b0));
  endtask

  task automatic test_history_clear();
    send_beat(sample_beat(16'sh1234, 1'b0));
    send_beat(sample_beat(16'shedcb, 1'b0));
    send_beat(sample_beat(16'sh7fff, 1'b1));
    send_beat(sample_beat(16'sh8000, 1'b0));
    send_beat(sample_beat(16'sh8000, 1'b1));
    send_beat(sample_beat(16'sh0000, 1'b1));
    send_beat(sample_beat(16'sh4000, 1'b0));
  endtask

  // runs of samples with occasional bursts of tap reloads in between
  task automatic test_random_stream();
    int sent;
    int run_len;
    bit drained;
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(coef_load($urandom_range(0, TAPS - 1), pick_q15()));
          sent++;
        end
      end
      run_len = $urandom_range(1, 40);
      for (int k = 0; k < run_len; k++) begin
        send_beat(sample_beat(pick_q15(), k == 0 ? 1'($urandom_range(0, 2) == 0)
                                                 : 1'($urandom_range(0, 30) == 0)));
        sent++;
      end
      // pause once midway until every result is back
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        wait_for_drain();
        drained = 1'b1;
      end
      if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
    end
  endtask

  initial begin
    for (int k = 0; k < TAPS; k++) begin
      tap_history[k] = '0;
      tap_coefs[k]   = '0;
    end
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_COEF;
    in_ch.coef_index   <= '0;
    in_ch.coef_value   <= '0;
    in_ch.sample_value <= '0;
    in_ch.first_sample <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_coef_fill();
    test_field_extremes();
    test_history_clear();
    test_random_stream();
    wait_for_drain();
    repeat (TAPS + 16) @(posedge clk);
    if (fail_count == 0 && expected_sums.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fir_pkg.sv
rtl/core/fir_if.sv
rtl/core/fir_cell.sv
rtl/core/fir_out.sv
rtl/core/fir_filter_direct_form.sv
dv/testbench.sv
